// File: src/vqe_pkg.sv
package vqe_pkg;

    // Command codes carried in the cmd field
    localparam logic CMD_CODEBOOK = 1'b0;
    localparam logic CMD_VECTOR   = 1'b1;

    // Configuration register indexes
    localparam int   CFG_IDX_W  = 1;
    localparam int   CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'b1;

    // Result distance width and its saturation value
    localparam int              DIST_W   = 22;
    localparam logic [DIST_W-1:0] DIST_MAX = 22'h3FFFFF;

    typedef struct packed {
        logic       cmd;
        logic [7:0] entry_index;
        logic [5:0] element_index;
        logic [7:0] sample;
        logic       last;
    } t_vqe_in;

    typedef struct packed {
        logic [7:0]        best_index;
        logic [DIST_W-1:0] best_distance;
    } t_vqe_out;

    // Control that travels with each memory read through the distance pipeline
    typedef struct packed {
        logic valid;
        logic first_elem;
        logic last_elem;
        logic first_code;
        logic last_code;
    } t_vqe_tag;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } t_vqe_state;

endpackage

// File: src/vq_nearest_codeword_encoder.sv
// Channel   Direction  Handshake                   Payload
// in        request    i_in_valid / o_in_ready     i_in_data  (t_vqe_in)
// out       result     o_out_valid / i_out_ready   o_out_data (t_vqe_out)
// cfg       write      i_cfg_we                    i_cfg_idx, i_cfg_wdata
//
// A codebook or vector request writes one byte. A vector request with last set
// also starts a search over every active codeword: the search reads one codebook byte and one
// vector byte per cycle from the two memories and accumulates one term per cycle.
// Requests are held off while a search runs; a finished result waits in the
// output register, and the next search ends by waiting for that register to free.
// Reset clears control and sets the configuration to active 256, length 4; both memories stay unset until written.
module vq_nearest_codeword_encoder
    import vqe_pkg::*;
#(
    parameter int MAX_CODES = 256,
    parameter int MAX_LEN   = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_vqe_in               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_vqe_out              o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int CAP    = MAX_CODES < 256 ? MAX_CODES : 256;
    localparam int CODE_W = CAP > 1 ? $clog2(CAP) : 1;
    localparam int LEN_W  = MAX_LEN > 1 ? $clog2(MAX_LEN) : 1;
    localparam int CB_W   = CODE_W + LEN_W;
    localparam int ACC_W  = $clog2(MAX_LEN * 65025 + 1);

    t_vqe_state        r_state;
    t_vqe_state        n_state;
    logic [8:0]        r_active;
    logic [6:0]        r_length;
    logic [CODE_W-1:0] r_code_cnt;
    logic [LEN_W-1:0]  r_elem_cnt;
    logic              r_out_valid;
    t_vqe_out          r_out;

    logic              in_acc;
    logic              load_out;
    logic              start;
    t_vqe_tag          issue_tag;
    logic [8:0]        eff_n;
    logic [8:0]        eff_len;
    logic [CODE_W-1:0] code_m1;
    logic [LEN_W-1:0]  len_m1;
    logic              vec_we;
    logic              cb_we;
    logic [7:0]        vec_byte;
    logic [7:0]        cb_byte;
    logic              dist_done;
    logic [7:0]        best_index;
    logic [DIST_W-1:0] best_dist;

    assign in_acc = i_in_valid && o_in_ready;
    assign start  = in_acc && i_in_data.cmd == CMD_VECTOR && i_in_data.last;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 9'd256;
            r_length <= 7'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACTIVE: r_active <= i_cfg_wdata;
                CFG_LENGTH: r_length <= i_cfg_wdata[6:0];
                default:    r_active <= r_active;
            endcase
        end
    end

    // Clamp the active count and vector length
    always_comb begin
        priority if (r_active == 9'd0) begin
            eff_n = 9'd1;
        end else if (r_active > 9'(CAP)) begin
            eff_n = 9'(CAP);
        end else begin
            eff_n = r_active;
        end
        priority if (r_length == 7'd0) begin
            eff_len = 9'd1;
        end else if ({2'b00, r_length} > 9'(MAX_LEN)) begin
            eff_len = 9'(MAX_LEN);
        end else begin
            eff_len = {2'b00, r_length};
        end
    end

    assign code_m1 = CODE_W'(eff_n - 9'd1);
    assign len_m1  = LEN_W'(eff_len - 9'd1);

    // Drop writes that fall outside the stores
    assign vec_we = in_acc && i_in_data.cmd == CMD_VECTOR
                    && 32'(i_in_data.element_index) < MAX_LEN;
    assign cb_we  = in_acc && i_in_data.cmd == CMD_CODEBOOK
                    && 32'(i_in_data.entry_index) < CAP
                    && 32'(i_in_data.element_index) < MAX_LEN;

    vqe_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (LEN_W'(i_in_data.element_index)),
        .i_wdata (i_in_data.sample),
        .i_raddr (r_elem_cnt),
        .o_rdata (vec_byte)
    );

    vqe_ram #(
        .WIDTH (8),
        .DEPTH (2 ** CB_W)
    ) u_cb_ram (
        .i_clk   (i_clk),
        .i_we    (cb_we),
        .i_waddr ({CODE_W'(i_in_data.entry_index), LEN_W'(i_in_data.element_index)}),
        .i_wdata (i_in_data.sample),
        .i_raddr ({r_code_cnt, r_elem_cnt}),
        .o_rdata (cb_byte)
    );

    vqe_dist #(
        .ACC_W  (ACC_W),
        .CODE_W (CODE_W)
    ) u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (issue_tag),
        .i_vec_byte   (vec_byte),
        .i_cb_byte    (cb_byte),
        .o_done       (dist_done),
        .o_best_index (best_index),
        .o_best_dist  (best_dist)
    );

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and read issue
    always_comb begin
        n_state   = r_state;
        issue_tag = '0;
        load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                issue_tag.valid      = 1'b1;
                issue_tag.first_elem = r_elem_cnt == '0;
                issue_tag.last_elem  = r_elem_cnt == len_m1;
                issue_tag.first_code = r_code_cnt == '0;
                issue_tag.last_code  = r_code_cnt == code_m1;
                if (issue_tag.last_elem && issue_tag.last_code) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (dist_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Advance the element and codeword counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_cnt <= '0;
            r_elem_cnt <= '0;
        end else if (r_state != ST_RUN) begin
            r_code_cnt <= '0;
            r_elem_cnt <= '0;
        end else if (r_elem_cnt == len_m1) begin
            r_elem_cnt <= '0;
            r_code_cnt <= r_code_cnt + 1'b1;
        end else begin
            r_elem_cnt <= r_elem_cnt + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.best_index    <= best_index;
            r_out.best_distance <= best_dist;
        end
    end

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: src/vqe_ram.sv
module vqe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/vqe_dist.sv
module vqe_dist
    import vqe_pkg::*;
#(
    parameter int ACC_W  = 24,
    parameter int CODE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_vqe_tag          i_tag,
    input  logic [7:0]        i_vec_byte,
    input  logic [7:0]        i_cb_byte,
    output logic              o_done,
    output logic [7:0]        o_best_index,
    output logic [DIST_W-1:0] o_best_dist
);

    localparam int CMP_W = ACC_W > DIST_W ? ACC_W : DIST_W;

    t_vqe_tag           r_tag0;
    t_vqe_tag           r_tag1;
    logic [15:0]        r_sq;
    logic [ACC_W-1:0]   r_acc;
    logic [CODE_W-1:0]  r_code;
    logic [ACC_W-1:0]   r_best_d;
    logic [CODE_W-1:0]  r_best_code;
    logic               r_done;

    logic signed [8:0]  diff;
    logic signed [17:0] sq_full;
    logic [ACC_W-1:0]   acc_sum;
    logic [CODE_W-1:0]  code_now;
    logic [CMP_W-1:0]   best_ext;

    // Square the element difference as the read data arrives
    assign diff    = $signed({1'b0, i_vec_byte}) - $signed({1'b0, i_cb_byte});
    assign sq_full = diff * diff;

    // Accumulate; restart at the first element of each codeword
    assign acc_sum  = (r_tag1.first_elem ? '0 : r_acc) + ACC_W'(r_sq);
    assign code_now = r_tag1.first_code ? '0 : r_code;

    // Control stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag0 <= '0;
            r_tag1 <= '0;
            r_done <= 1'b0;
        end else begin
            r_tag0 <= i_tag;
            r_tag1 <= r_tag0;
            r_done <= r_tag1.valid && r_tag1.last_elem && r_tag1.last_code;
        end
    end

    // Datapath stages: square, accumulate, keep the best codeword
    always_ff @(posedge i_clk) begin
        r_sq <= sq_full[15:0];
        if (r_tag1.valid) begin
            r_acc <= acc_sum;
            if (r_tag1.last_elem) begin
                r_code <= code_now + 1'b1;
                // Strict compare keeps the lower index on ties
                if (r_tag1.first_code || acc_sum < r_best_d) begin
                    r_best_d    <= acc_sum;
                    r_best_code <= code_now;
                end
            end
        end
    end

    // Saturate the distance to the result width
    assign best_ext     = CMP_W'(r_best_d);
    assign o_best_dist  = (best_ext > CMP_W'(DIST_MAX)) ? DIST_MAX : best_ext[DIST_W-1:0];
    assign o_best_index = 8'(r_best_code);
    assign o_done       = r_done;

endmodule
